FILE: rtl/tmt_pkg.sv
// Shared types and constants for the target merge table.
package tmt_pkg;

   localparam int TMT_DEPTH_DEFAULT = 16;
   localparam int POS_W             = 16;
   localparam int RADIUS_W          = 15;
   localparam int SLOT_W            = 4;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd384;

   // mode codes
   localparam logic MODE_REPORT = 1'b0;
   localparam logic MODE_FETCH  = 1'b1;

   typedef struct packed {
      logic                    mode;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
   } tmt_req_type;

   typedef struct packed {
      logic                    merged;
      logic                    appended;
      logic                    dropped_full;
      logic [SLOT_W-1:0]       slot;
      logic                    task_ready;
      logic signed [POS_W-1:0] task_x;
      logic signed [POS_W-1:0] task_y;
      logic signed [POS_W-1:0] task_z;
   } tmt_rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
   } tmt_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH,
      ST_POST
   } tmt_state_type;

   // floor((a + b) / 2) on the 17-bit sum
   function automatic logic signed [POS_W-1:0] avg_floor(
      input logic signed [POS_W-1:0] a,
      input logic signed [POS_W-1:0] b
   );
      logic [POS_W:0] sum;
      sum = {a[POS_W-1], a} + {b[POS_W-1], b};
      return sum[POS_W:1];
   endfunction

   // |a - b| < radius, with the difference held at 17 bits
   function automatic logic near_axis(
      input logic signed [POS_W-1:0] a,
      input logic signed [POS_W-1:0] b,
      input logic [RADIUS_W-1:0]     radius
   );
      logic [POS_W:0] diff;
      logic [POS_W:0] mag;
      diff = {a[POS_W-1], a} - {b[POS_W-1], b};
      mag  = diff[POS_W] ? (~diff + 1'b1) : diff;
      return mag < (POS_W+1)'(radius);
   endfunction

endpackage

FILE: rtl/target_merge_table.sv
// Target merge table: report merge/append/drop and task fetch over one entry memory.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+--------------------------
//  req     | in        | req_valid/stall   | mode, pos_x, pos_y, pos_z
//  rsp     | out       | rsp_valid/stall   | merged .. task_z
//  csr     | in        | csr_valid/ready   | match_radius (15 bits)
//
// A report scans the table: the scan reads one entry per cycle from the table memory,
// compares it in the next cycle, and a post step moves the result into the output
// register. A fetch reads the entry at the dispatch pointer before the post step and
// skips to it with nothing pending. One transaction is in flight at a time: req_stall
// stays high until the result is loaded, and rsp_stall holds the post step. Reset
// clears count and pointer and sets radius to 384 (1.5 m); the memory is not cleared.
module target_merge_table #(
   parameter int TABLE_DEPTH = tmt_pkg::TMT_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tmt_pkg::tmt_req_type           req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tmt_pkg::tmt_rsp_type           rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tmt_pkg::RADIUS_W-1:0]   csr_data
);
   import tmt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Table memory: one write port, one registered read port.
   tmt_entry_type mem [TABLE_DEPTH];
   tmt_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   tmt_entry_type    wr_data;

   tmt_state_type state_ff, state_in;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    dp_ff, dp_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                cmp_vld_ff, cmp_vld_in;
   tmt_req_type         item_ff, item_in;
   tmt_rsp_type         res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tmt_rsp_type         rsp_data_ff, rsp_data_in;

   logic             req_take;
   logic             out_free;
   logic             fetch_pending;
   logic             scan_hit;
   logic             scan_end;
   logic [CNT_W-1:0] cmp_next_cnt;

   // Handshake decodes.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign fetch_pending = (dp_ff < count_ff);

   // Scan compare on the entry read last cycle.
   assign cmp_next_cnt = CNT_W'(cmp_idx_ff) + CNT_W'(1);
   assign scan_hit = cmp_vld_ff
                  && near_axis(item_ff.pos_x, rd_data_ff.x, radius_ff)
                  && near_axis(item_ff.pos_y, rd_data_ff.y, radius_ff);
   // Scan ends without a hit on an empty table or after the last entry.
   assign scan_end = (count_ff == '0)
                  || (cmp_vld_ff && !scan_hit && (cmp_next_cnt == count_ff));

   // Read the scan index while scanning, else the dispatch pointer.
   assign rd_addr = (state_ff == ST_SCAN) ? rd_idx_ff[IDX_W-1:0] : dp_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_data.mode == MODE_REPORT) begin
                  state_in = ST_SCAN;
               end else if (fetch_pending) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_SCAN: begin
            if (scan_hit || scan_end) begin
               state_in = ST_POST;
            end
         end
         ST_FETCH: begin
            state_in = ST_POST;
         end
         ST_POST: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      radius_in    = radius_ff;
      count_in     = count_ff;
      dp_in        = dp_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      item_in      = item_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      wr_addr      = cmp_idx_ff;
      wr_data      = rd_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid && csr_ready) begin
         radius_in = csr_data;
      end

      // Drop the held result once taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               item_in   = req_data;
               rd_idx_in = '0;
               res_in    = '0;
            end
         end
         ST_SCAN: begin
            // Advance the read pointer; flag a compare only for valid entries.
            rd_idx_in  = rd_idx_ff + CNT_W'(1);
            cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            cmp_vld_in = (rd_idx_ff < count_ff);
            if (scan_hit) begin
               mem_we      = 1'b1;
               wr_addr     = cmp_idx_ff;
               wr_data.x   = avg_floor(rd_data_ff.x, item_ff.pos_x);
               wr_data.y   = avg_floor(rd_data_ff.y, item_ff.pos_y);
               wr_data.z   = avg_floor(rd_data_ff.z, item_ff.pos_z);
               res_in.merged = 1'b1;
               res_in.slot   = SLOT_W'(cmp_idx_ff);
            end else if (scan_end) begin
               if (count_ff < DEPTH_CNT) begin
                  mem_we          = 1'b1;
                  wr_addr         = count_ff[IDX_W-1:0];
                  wr_data.x       = item_ff.pos_x;
                  wr_data.y       = item_ff.pos_y;
                  wr_data.z       = item_ff.pos_z;
                  res_in.appended = 1'b1;
                  res_in.slot     = SLOT_W'(count_ff[IDX_W-1:0]);
                  count_in        = count_ff + CNT_W'(1);
               end else begin
                  res_in.dropped_full = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            res_in.task_ready = 1'b1;
            res_in.slot       = SLOT_W'(dp_ff[IDX_W-1:0]);
            res_in.task_x     = rd_data_ff.x;
            res_in.task_y     = rd_data_ff.y;
            res_in.task_z     = rd_data_ff.z;
            dp_in             = dp_ff + CNT_W'(1);
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_RESET;
         count_ff     <= '0;
         dp_ff        <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         count_ff     <= count_in;
         dp_ff        <= dp_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("entry count beyond table depth");

   a_dp_bound: assert property (@(posedge clock) disable iff (reset)
      dp_ff <= count_ff)
      else $error("dispatch pointer passed entry count");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_SCAN))
      else $error("table write outside a scan");

   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_POST))
      else $error("result raised outside the post step");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.merged, rsp_data_ff.appended,
                                 rsp_data_ff.dropped_full, rsp_data_ff.task_ready}))
      else $error("more than one outcome flag in a result");
`endif

endmodule
